// File: src/r2p_pkg.sv
// shared constants, arctangent table and pipeline word type for the polar converter
package r2p_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int STAGE_COUNT  = 16;
    localparam int GUARD_BITS   = 16;

    localparam int PHASE_W    = 32;
    localparam int XY_W       = SAMPLE_WIDTH + GUARD_BITS + 2;
    localparam int SQ_W       = 2 * SAMPLE_WIDTH;
    localparam int TRIAL_W    = SQ_W + 1;
    localparam int CELL_COUNT = (STAGE_COUNT > SAMPLE_WIDTH) ? STAGE_COUNT : SAMPLE_WIDTH;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int DIG_W      = $clog2(SAMPLE_WIDTH);
    localparam int TAB_LEN    = 32;
    localparam int TAB_IDX_W  = 5;
    localparam int ANGLE_DROP = PHASE_W - SAMPLE_WIDTH;

    localparam logic [PHASE_W-1:0] PHASE_PI   = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PHASE_HALF =
        (ANGLE_DROP == 0) ? '0 : PHASE_W'(64'd1 << (ANGLE_DROP - 1));

    localparam logic [PHASE_W-1:0] ATAN_TABLE [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef logic [IDX_W-1:0] t_stage_idx;

    typedef struct packed {
        logic                      zero;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic [PHASE_W-1:0]        phase;
        logic [SAMPLE_WIDTH-1:0]   root;
        logic [SQ_W-1:0]           rem;
    } t_cell_word;

endpackage

// File: src/r2p_if.sv
// valid/ready channels for complex samples in and polar words out

interface r2p_in_if;
    import r2p_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;
    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface r2p_out_if;
    import r2p_pkg::*;
    logic                           valid;
    logic                           ready;
    logic        [SAMPLE_WIDTH-1:0] magnitude;
    logic signed [SAMPLE_WIDTH-1:0] angle;
    modport source (output valid, output magnitude, output angle, input ready);
    modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

// File: src/r2p_front.sv
// entry stage: squares, half-plane fold and initial cordic vector
module r2p_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]  i_real,
    input  logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]  i_imag,
    output logic                                     o_ready,
    input  logic                                     i_ready,
    output logic                                     o_valid,
    output r2p_pkg::t_cell_word                      o_word
);
    import r2p_pkg::*;

    logic                   r_valid;
    t_cell_word             r_word;
    t_cell_word             n_word;
    logic signed [SQ_W-1:0] re_sq;
    logic signed [SQ_W-1:0] im_sq;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic                   load;

    assign re_sq = i_real * i_real;
    assign im_sq = i_imag * i_imag;
    assign x0    = XY_W'(i_real) <<< GUARD_BITS;
    assign y0    = XY_W'(i_imag) <<< GUARD_BITS;
    assign load  = !r_valid || i_ready;

    always_comb begin
        n_word.zero  = (i_real == '0) && (i_imag == '0);
        n_word.root  = '0;
        n_word.rem   = $unsigned(re_sq) + $unsigned(im_sq);
        if (i_real < 0) begin
            n_word.x     = -x0;
            n_word.y     = -y0;
            n_word.phase = PHASE_PI;
        end else begin
            n_word.x     = x0;
            n_word.y     = y0;
            n_word.phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: src/r2p_cell.sv
// one pipeline cell: a cordic micro-rotation and one square-root digit
module r2p_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  r2p_pkg::t_stage_idx   i_stage,
    input  logic                  i_valid,
    input  r2p_pkg::t_cell_word   i_word,
    output logic                  o_ready,
    input  logic                  i_ready,
    output logic                  o_valid,
    output r2p_pkg::t_cell_word   o_word
);
    import r2p_pkg::*;

    logic                    r_valid;
    t_cell_word              r_word;
    t_cell_word              n_word;
    logic                    do_rot;
    logic                    do_dig;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic [PHASE_W-1:0]      atan_val;
    logic [DIG_W-1:0]        digit;
    logic [DIG_W:0]          root_shift;
    logic [DIG_W:0]          bit_shift;
    logic [TRIAL_W-1:0]      trial;
    logic                    load;

    assign do_rot     = {1'b0, i_stage} < (IDX_W + 1)'(STAGE_COUNT);
    assign do_dig     = {1'b0, i_stage} < (IDX_W + 1)'(SAMPLE_WIDTH);
    assign xs         = i_word.x >>> i_stage;
    assign ys         = i_word.y >>> i_stage;
    assign atan_val   = ATAN_TABLE[TAB_IDX_W'(i_stage)];
    assign digit      = DIG_W'(SAMPLE_WIDTH - 1) - DIG_W'(i_stage);
    assign root_shift = {1'b0, digit} + 1'b1;
    assign bit_shift  = {digit, 1'b0};
    assign trial      = (TRIAL_W'(i_word.root) << root_shift)
                      + (TRIAL_W'(1) << bit_shift);
    assign load       = !r_valid || i_ready;

    always_comb begin
        n_word = i_word;
        if (do_rot) begin
            if (!i_word.y[XY_W-1]) begin
                n_word.x     = i_word.x + ys;
                n_word.y     = i_word.y - xs;
                n_word.phase = i_word.phase + atan_val;
            end else begin
                n_word.x     = i_word.x - ys;
                n_word.y     = i_word.y + xs;
                n_word.phase = i_word.phase - atan_val;
            end
        end
        if (do_dig && (TRIAL_W'(i_word.rem) >= trial)) begin
            n_word.rem  = i_word.rem - trial[SQ_W-1:0];
            n_word.root = i_word.root | (SAMPLE_WIDTH'(1) << digit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: src/r2p_back.sv
// exit stage: magnitude rounding, angle rounding and output register
module r2p_back (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  r2p_pkg::t_cell_word                      i_word,
    output logic                                     o_ready,
    input  logic                                     i_ready,
    output logic                                     o_valid,
    output logic        [r2p_pkg::SAMPLE_WIDTH-1:0]  o_magnitude,
    output logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]  o_angle
);
    import r2p_pkg::*;

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_mag;
    logic [SAMPLE_WIDTH-1:0] r_ang;
    logic [SAMPLE_WIDTH-1:0] n_mag;
    logic [SAMPLE_WIDTH-1:0] n_ang;
    logic [PHASE_W-1:0]      phase_rnd;
    logic                    load;

    assign phase_rnd = i_word.phase + PHASE_HALF;
    assign load      = !r_valid || i_ready;

    always_comb begin
        if (i_word.zero) begin
            n_mag = '0;
            n_ang = '0;
        end else begin
            n_mag = (i_word.rem > SQ_W'(i_word.root)) ? i_word.root + 1'b1 : i_word.root;
            n_ang = phase_rnd[PHASE_W-1 -: SAMPLE_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mag <= n_mag;
            r_ang <= n_ang;
        end
    end

    assign o_ready     = load;
    assign o_valid     = r_valid;
    assign o_magnitude = r_mag;
    assign o_angle     = $signed(r_ang);

endmodule

// File: src/rect_to_polar_converter_top.sv
// Rectangular to polar converter: takes one complex sample per cycle unless the output stalls
// and returns its rounded magnitude and its angle in units of pi/2^(SAMPLE_WIDTH-1) from a
// CORDIC in vectoring mode. The datapath is a chain of CELL_COUNT identical cells between an
// entry and an exit register (16 cell registers plus the entry and exit registers at the
// default sizes); each cell does one micro-rotation and resolves one bit of the square root.
// Throughput is one word per cycle while the output is not stalled. Every stage holds its
// word when the next one is full, so a stalled output only blocks the input once the whole
// chain is full, and bubbles are squeezed out.
module rect_to_polar_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    r2p_in_if.sink     i_sample,
    r2p_out_if.source  o_polar
);
    import r2p_pkg::*;

    t_cell_word chain_word  [CELL_COUNT+1];
    logic       chain_valid [CELL_COUNT+1];
    logic       chain_ready [CELL_COUNT+1];

    r2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sample.valid),
        .i_real  (i_sample.real_part),
        .i_imag  (i_sample.imag_part),
        .o_ready (i_sample.ready),
        .i_ready (chain_ready[0]),
        .o_valid (chain_valid[0]),
        .o_word  (chain_word[0])
    );

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        r2p_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (IDX_W'(g)),
            .i_valid (chain_valid[g]),
            .i_word  (chain_word[g]),
            .o_ready (chain_ready[g]),
            .i_ready (chain_ready[g+1]),
            .o_valid (chain_valid[g+1]),
            .o_word  (chain_word[g+1])
        );
    end

    r2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chain_valid[CELL_COUNT]),
        .i_word      (chain_word[CELL_COUNT]),
        .o_ready     (chain_ready[CELL_COUNT]),
        .i_ready     (o_polar.ready),
        .o_valid     (o_polar.valid),
        .o_magnitude (o_polar.magnitude),
        .o_angle     (o_polar.angle)
    );

endmodule

// File: src/r2p_checker.sv
// port-level checks for the polar converter and their bind to the top level
module r2p_checker (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_in_ready,
    input logic                                     i_out_valid,
    input logic                                     i_out_ready,
    input logic        [r2p_pkg::SAMPLE_WIDTH-1:0]  i_magnitude,
    input logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]  i_angle
);
    import r2p_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // the input side only stalls when the chain is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while output side can move");

    // only the zero sample has zero length, and it has angle zero
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_magnitude == '0)) |-> (i_angle == '0))
        else $error("zero magnitude with nonzero angle");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_magnitude) && $stable(i_angle)))
        else $error("output word changed while stalled");

endmodule

bind rect_to_polar_converter_top r2p_checker u_r2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_polar.valid),
    .i_out_ready (o_polar.ready),
    .i_magnitude (o_polar.magnitude),
    .i_angle     (o_polar.angle)
);

// File: tb/sv/rect_to_polar_converter_top_test.sv
// testbench for the polar converter: every result word checked against a typed expected word or a cordic predictor
`timescale 1ns / 1ps

module rect_to_polar_converter_top_test;
    import r2p_pkg::*;

    localparam int ARCTAN_LEN   = 32;
    localparam int PHASE_DROP   = 32 - SAMPLE_WIDTH;
    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM   = 850;
    localparam int LONG_HOLD    = 300;

    localparam logic [31:0] ARCTAN_PHASE [ARCTAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic        [SAMPLE_WIDTH-1:0] magnitude;
        logic signed [SAMPLE_WIDTH-1:0] angle;
    } t_polar_word;

    typedef struct packed {
        logic        typed;
        t_polar_word word;
    } t_offered_word;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           typed;
        t_polar_word                    word;
    } t_sample_row;

    logic i_clk;
    logic i_rst_n;

    r2p_in_if  smp ();
    r2p_out_if pol ();

    rect_to_polar_converter_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_polar  (pol)
    );

    t_offered_word offered_q [$];
    t_polar_word   pending_polar [$];
    int            error_count  = 0;
    int            result_count = 0;
    bit            hold_request = 1'b0;
    t_sample_row   directed_rows [NUM_DIRECTED];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("rect_to_polar_converter_top: mismatch");
        $finish;
    end

    function automatic t_polar_word polar_of(input logic signed [SAMPLE_WIDTH-1:0] re,
                                             input logic signed [SAMPLE_WIDTH-1:0] im);
        longint          x, y, xs, ys;
        longint unsigned sq, root, bitv, rem;
        logic [31:0]     phase;
        logic [32:0]     rounded;
        t_polar_word     res;
        res   = '0;
        phase = '0;
        if (re == 0 && im == 0) begin
            return res;
        end
        sq   = longint'(longint'(re) * longint'(re) + longint'(im) * longint'(im));
        root = 0;
        rem  = sq;
        bitv = 64'd1 << 62;
        while (bitv > rem) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem > root) begin
            root = root + 1;
        end
        res.magnitude = root[SAMPLE_WIDTH-1:0];

        x = longint'(re) * 65536;
        y = longint'(im) * 65536;
        if (x < 0) begin
            x     = -x;
            y     = -y;
            phase = 32'h8000_0000;
        end
        for (int i = 0; i < STAGE_COUNT && i < ARCTAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x     = x + ys;
                y     = y - xs;
                phase = phase + ARCTAN_PHASE[i];
            end else begin
                x     = x - ys;
                y     = y + xs;
                phase = phase - ARCTAN_PHASE[i];
            end
        end
        if (PHASE_DROP == 0) begin
            res.angle = phase[SAMPLE_WIDTH-1:0];
        end else begin
            rounded   = {1'b0, phase} + (33'd1 << (PHASE_DROP - 1));
            res.angle = rounded[PHASE_DROP +: SAMPLE_WIDTH];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $realtime, what);
        error_count++;
    endtask

    // input and output words observed on the same edge
    always @(posedge i_clk) begin
        t_offered_word ow;
        t_polar_word   exp_word;
        if (i_rst_n) begin
            if (smp.valid && smp.ready) begin
                if (offered_q.size() == 0) begin
                    report_mismatch("input word accepted that was never offered");
                end else begin
                    ow = offered_q.pop_front();
                    exp_word = ow.typed ? ow.word : polar_of(smp.real_part, smp.imag_part);
                    pending_polar.push_back(exp_word);
                end
            end
            if (pol.valid && pol.ready) begin
                result_count++;
                if (pending_polar.size() == 0) begin
                    report_mismatch($sformatf("unexpected word mag=%0d ang=%0d",
                                              pol.magnitude, pol.angle));
                end else begin
                    exp_word = pending_polar.pop_front();
                    if (pol.magnitude !== exp_word.magnitude) begin
                        report_mismatch($sformatf("word %0d magnitude %0d, expected %0d",
                                                  result_count, pol.magnitude,
                                                  exp_word.magnitude));
                    end
                    if (pol.angle !== exp_word.angle) begin
                        report_mismatch($sformatf("word %0d angle %0d, expected %0d",
                                                  result_count, pol.angle, exp_word.angle));
                    end
                end
            end
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        pol.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else if ((taken / 80) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 12);
            end
            if (stall > 0) begin
                pol.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pol.ready <= 1'b1;
            do @(posedge i_clk); while (!pol.valid);
            taken++;
        end
    end

    task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                                input logic signed [SAMPLE_WIDTH-1:0] im,
                                input logic typed, input t_polar_word word, input int gap);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_q.push_back('{typed: typed, word: word});
        smp.valid     <= 1'b1;
        smp.real_part <= re;
        smp.imag_part <= im;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (pending_polar.size() != 0 || offered_q.size() != 0);
    endtask

    initial begin
        logic signed [SAMPLE_WIDTH-1:0] re, im;
        int gap;
        int burst_left;

        directed_rows = '{
            '{0,      0,      1'b1, '{0,     0}},
            '{32767,  0,      1'b1, '{32767, 0}},
            '{0,      32767,  1'b1, '{32767, 16384}},
            '{0,      -32768, 1'b1, '{32768, -16384}},
            '{-32768, 0,      1'b1, '{32768, -32768}},
            '{-1,     0,      1'b1, '{1,     -32768}},
            '{1,      0,      1'b1, '{1,     0}},
            '{-32768, -32768, 1'b1, '{46341, -24576}},
            '{32767,  32767,  1'b1, '{46340, 8192}},
            '{0,      1,      1'b1, '{1,     16384}},
            '{0,      -1,     1'b1, '{1,     -16384}},
            '{-32768, 32767,  1'b0, '{0, 0}},
            '{32767,  -32768, 1'b0, '{0, 0}},
            '{-32768, 1,      1'b0, '{0, 0}},
            '{-32768, -1,     1'b0, '{0, 0}},
            '{1,      -1,     1'b0, '{0, 0}},
            '{-1,     1,      1'b0, '{0, 0}},
            '{-1,     -1,     1'b0, '{0, 0}},
            '{21845,  -10923, 1'b0, '{0, 0}},
            '{-21846, 10922,  1'b0, '{0, 0}},
            '{-32767, -1,     1'b0, '{0, 0}},
            '{16384,  16384,  1'b0, '{0, 0}}
        };

        i_rst_n       <= 1'b0;
        smp.valid     <= 1'b0;
        smp.real_part <= '0;
        smp.imag_part <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_sample(directed_rows[k].re, directed_rows[k].im, directed_rows[k].typed,
                         directed_rows[k].word, $urandom_range(0, 3));
        end
        drain_results();

        burst_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    re = SAMPLE_WIDTH'($urandom());
                    im = SAMPLE_WIDTH'($urandom());
                end
                6, 7: begin
                    re = SAMPLE_WIDTH'(int'($urandom_range(0, 32)) - 16);
                    im = SAMPLE_WIDTH'(int'($urandom_range(0, 32)) - 16);
                end
                8: begin
                    re = {SAMPLE_WIDTH{1'b0}};
                    im = {SAMPLE_WIDTH{1'b0}};
                    case ($urandom_range(0, 4))
                        0: re = -32768;
                        1: re = 32767;
                        2: re = -1;
                        3: re = 1;
                        default: re = 0;
                    endcase
                    case ($urandom_range(0, 4))
                        0: im = -32768;
                        1: im = 32767;
                        2: im = -1;
                        3: im = 1;
                        default: im = 0;
                    endcase
                end
                default: begin
                    // near the negative real axis, where the angle wraps
                    re = SAMPLE_WIDTH'(-int'($urandom_range(1, 32768)));
                    im = SAMPLE_WIDTH'(int'($urandom_range(0, 4)) - 2);
                end
            endcase

            if (n == 300) begin
                hold_request = 1'b1;
                burst_left   = 80;
            end
            if (n == 600) begin
                drain_results();
            end
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else if ((n / 64) % 3 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 12);
            end
            offer_sample(re, im, 1'b0, '0, gap);
        end
        drain_results();
        repeat (40) @(posedge i_clk);

        if (error_count == 0) begin
            $display("rect_to_polar_converter_top: match");
        end else begin
            $display("rect_to_polar_converter_top: mismatch");
        end
        $finish;
    end

endmodule
